/* src/nhrc_pkg.sv */
// Shared types and constants for the nearest-hit ray caster.
// Used by nhrc_mac, nhrc_divsqrt and nearest_hit_ray_caster; no dependencies.
package nhrc_pkg;

  localparam int MUL_W  = 34;   // multiplier operand width, signed
  localparam int PROD_W = 68;
  localparam int ACC_W  = 144;  // accumulator width, signed
  localparam int NUM_W  = 72;   // quotient numerator / denominator width
  localparam int RAD_W  = 136;  // square root radicand width
  localparam int ROOT_W = 68;
  localparam int DIST_W = 31;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [1:0] KIND_SPHERE = 2'd1;
  localparam logic [1:0] KIND_PLANE  = 2'd2;
  localparam logic       OPC_WRITE   = 1'b0;
  localparam logic       OPC_CAST    = 1'b1;

  typedef struct packed {
    logic                    valid;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
    logic [2:0]              sh;   // product shifted left by 32*sh
    logic                    neg;
    logic                    clr;
  } mac_op_t;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } ds_req_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic [30:0]        radius;
  } entry_t;

endpackage

/* src/nearest_hit_ray_caster.sv */
// Nearest-hit ray caster top level: object table, cast sequencer, output
// register. Depends on nhrc_pkg, nhrc_mac and nhrc_divsqrt.
//
// Input words arrive on s_t*. A write word stores one table entry and
// gives no result; a cast word tests entries 0 .. min(object_count,
// MAX_ENTRIES)-1, skipping entry_index when skip_enable is set, and gives
// one result word on m_t*. object_count is set through cfg_valid/cfg_data;
// the user must do so only while the block is idle, which the block itself
// does not enforce. A sphere test that reaches the root runs a 68-step
// square root and up to two quotient runs of up to 31 steps in the shared
// divide/root unit; the products come from the multiply-accumulate sequence.
// s_tready is low for the whole of a cast.
// The result sits in an output register: a new word is taken while it
// waits, and a cast that finishes while it is still held waits for m_tready.
// Reset clears object_count and the handshake state; the table holds
// whatever it held until entries are written again.
module nearest_hit_ray_caster #(
  parameter int MAX_ENTRIES = 128,
  parameter int FRAC_BITS   = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // entry_index[6:0], primitive_kind[8:7], vec_a_x[40:9], vec_a_y[72:41],
  // vec_a_z[104:73], vec_b_x[136:105], vec_b_y[168:137], vec_b_z[200:169],
  // sphere_radius[231:201], skip_enable[232], zero fill
  input  logic [239:0] s_tdata,
  // opcode[0]
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit[0], hit_distance[31:1], hit_entry[38:32], zero fill
  output logic [39:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data
);
  import nhrc_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {S_IDLE, S_LOOP, S_FETCH, S_MAC, S_WAIT, S_DS, S_DONE} state_t;
  typedef enum logic [2:0] {PH_A, PH_H, PH_C, PH_DISC, PH_PDEN, PH_PNUM} phase_t;

  state_t state;
  phase_t phase;

  // input word fields
  logic [6:0]         in_index;
  entry_t             in_entry;
  logic               in_skip;
  logic [31:0]        in_index_ext;
  logic               accept;
  logic               wr_en;

  assign in_index        = s_tdata[6:0];
  assign in_entry.kind   = s_tdata[8:7];
  assign in_entry.px     = s_tdata[40:9];
  assign in_entry.py     = s_tdata[72:41];
  assign in_entry.pz     = s_tdata[104:73];
  assign in_entry.nx     = s_tdata[136:105];
  assign in_entry.ny     = s_tdata[168:137];
  assign in_entry.nz     = s_tdata[200:169];
  assign in_entry.radius = s_tdata[231:201];
  assign in_skip         = s_tdata[232];
  assign in_index_ext    = 32'(in_index);

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign wr_en     = accept && (s_tuser[0] == OPC_WRITE) && (in_index_ext < MAX_ENTRIES);

  // object table
  entry_t mem [MAX_ENTRIES];
  entry_t rd;
  logic [CW-1:0] i;

  always_ff @(posedge clk) begin
    if (wr_en) mem[in_index_ext[AW-1:0]] <= in_entry;
    rd <= mem[i[AW-1:0]];
  end

  logic [7:0]          object_count;
  logic [CW-1:0]       limit;
  logic signed [31:0]  ox, oy, oz, dx, dy, dz;
  logic                skip_en;
  logic [6:0]          skip_idx;
  logic signed [32:0]  lx, ly, lz;
  logic signed [31:0]  nx, ny, nz;
  logic [30:0]         rad;
  logic                is_sphere;
  logic                far;
  logic                root_run;
  logic [63:0]         a_reg;
  logic signed [67:0]  h_reg;
  logic signed [67:0]  den_reg;
  logic [ROOT_W-1:0]   s_reg;
  logic [127:0]        hm, am, cm;
  logic                c_neg;
  logic                part;
  logic [1:0]          ii, jj;
  logic                w;
  logic                best_hit;
  logic [DIST_W-1:0]   best_t;
  logic [6:0]          best_i;
  logic                out_hit;
  logic [DIST_W-1:0]   out_dist;
  logic [6:0]          out_entry;
  logic [31:0]         i_ext;

  assign i_ext   = 32'(i);
  assign m_tdata = {1'b0, out_entry, out_dist, out_hit};

  // shared units
  mac_op_t                  op;
  logic signed [ACC_W-1:0]  acc;
  logic signed [67:0]       acc_lo;
  ds_req_t                  ds_req;
  logic signed [NUM_W-1:0]  ds_num;
  logic [NUM_W-1:0]         ds_den;
  logic [RAD_W-1:0]         ds_rad;
  logic                     ds_done;
  logic [DIST_W-1:0]        ds_q;
  logic [ROOT_W-1:0]        ds_root;

  assign acc_lo = acc[67:0];

  nhrc_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (op),
    .acc (acc)
  );

  nhrc_divsqrt #(.FRAC_BITS(FRAC_BITS)) u_ds (
    .clk  (clk),
    .rst  (rst),
    .req  (ds_req),
    .num  (ds_num),
    .den  (ds_den),
    .rad  (ds_rad),
    .done (ds_done),
    .q    (ds_q),
    .root (ds_root)
  );

  logic mac_last;

  // operand selection for the current multiply-accumulate step
  always_comb begin
    op       = '0;
    op.valid = (state == S_MAC);
    op.clr   = !part && (ii == 2'd0) && (jj == 2'd0);
    mac_last = 1'b0;
    unique case (phase)
      PH_A: begin
        unique case (jj)
          2'd0:    begin op.a = MUL_W'(dx); op.b = MUL_W'(dx); end
          2'd1:    begin op.a = MUL_W'(dy); op.b = MUL_W'(dy); end
          default: begin op.a = MUL_W'(dz); op.b = MUL_W'(dz); end
        endcase
        mac_last = (jj == 2'd2);
      end
      PH_H: begin
        unique case (jj)
          2'd0:    begin op.a = MUL_W'(dx); op.b = MUL_W'(lx); end
          2'd1:    begin op.a = MUL_W'(dy); op.b = MUL_W'(ly); end
          default: begin op.a = MUL_W'(dz); op.b = MUL_W'(lz); end
        endcase
        mac_last = (jj == 2'd2);
      end
      PH_C: begin
        unique case (jj)
          2'd0: begin op.a = MUL_W'(lx); op.b = MUL_W'(lx); end
          2'd1: begin op.a = MUL_W'(ly); op.b = MUL_W'(ly); end
          2'd2: begin op.a = MUL_W'(lz); op.b = MUL_W'(lz); end
          default: begin
            op.a   = $signed({3'b000, rad});
            op.b   = $signed({3'b000, rad});
            op.neg = 1'b1;
          end
        endcase
        mac_last = (jj == 2'd3);
      end
      PH_DISC: begin
        // h*h minus a*c over 32-bit limbs of the magnitudes
        op.sh = 3'(ii) + 3'(jj);
        if (!part) begin
          op.a = $signed({2'b00, hm[{ii, 5'b00000} +: 32]});
          op.b = $signed({2'b00, hm[{jj, 5'b00000} +: 32]});
        end else begin
          op.a   = $signed({2'b00, am[{ii, 5'b00000} +: 32]});
          op.b   = $signed({2'b00, cm[{jj, 5'b00000} +: 32]});
          op.neg = !c_neg;
        end
        mac_last = part && (ii == 2'd1) && (jj == 2'd2);
      end
      PH_PDEN: begin
        unique case (jj)
          2'd0:    begin op.a = MUL_W'(nx); op.b = MUL_W'(dx); end
          2'd1:    begin op.a = MUL_W'(ny); op.b = MUL_W'(dy); end
          default: begin op.a = MUL_W'(nz); op.b = MUL_W'(dz); end
        endcase
        mac_last = (jj == 2'd2);
      end
      PH_PNUM: begin
        unique case (jj)
          2'd0:    begin op.a = MUL_W'(nx); op.b = MUL_W'(lx); end
          2'd1:    begin op.a = MUL_W'(ny); op.b = MUL_W'(ly); end
          default: begin op.a = MUL_W'(nz); op.b = MUL_W'(lz); end
        endcase
        mac_last = (jj == 2'd2);
      end
      default: mac_last = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      object_count <= '0;
      m_tvalid     <= 1'b0;
      ds_req       <= '0;
    end else begin
      ds_req <= '0;
      if (cfg_valid) object_count <= cfg_data;
      // a new result loads in S_DONE instead
      if (m_tvalid && m_tready && (state != S_DONE)) m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (accept && (s_tuser[0] == OPC_CAST)) begin
            ox <= in_entry.px;
            oy <= in_entry.py;
            oz <= in_entry.pz;
            dx <= in_entry.nx;
            dy <= in_entry.ny;
            dz <= in_entry.nz;
            skip_en  <= in_skip;
            skip_idx <= in_index;
            limit    <= (32'(object_count) < MAX_ENTRIES) ? CW'(object_count)
                                                          : CW'(MAX_ENTRIES);
            i        <= '0;
            best_hit <= 1'b0;
            best_t   <= '0;
            best_i   <= '0;
            state    <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (i >= limit) begin
            state <= S_DONE;
          end else if (skip_en && (i_ext == 32'(skip_idx))) begin
            i <= i + CW'(1);
          end else begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          lx   <= 33'(ox) - 33'(rd.px);
          ly   <= 33'(oy) - 33'(rd.py);
          lz   <= 33'(oz) - 33'(rd.pz);
          nx   <= rd.nx;
          ny   <= rd.ny;
          nz   <= rd.nz;
          rad  <= rd.radius;
          far  <= 1'b0;
          part <= 1'b0;
          ii   <= '0;
          jj   <= '0;
          if (rd.kind == KIND_SPHERE) begin
            is_sphere <= 1'b1;
            phase     <= PH_A;
            state     <= S_MAC;
          end else if (rd.kind == KIND_PLANE) begin
            is_sphere <= 1'b0;
            phase     <= PH_PDEN;
            state     <= S_MAC;
          end else begin
            // empty or unknown kind: never hit
            i     <= i + CW'(1);
            state <= S_LOOP;
          end
        end
        S_MAC: begin
          if (mac_last) begin
            w     <= 1'b0;
            state <= S_WAIT;
          end else if (phase == PH_DISC) begin
            if (jj == 2'd2) begin
              jj <= '0;
              if (!part && (ii == 2'd2)) begin
                ii   <= '0;
                part <= 1'b1;
              end else begin
                ii <= ii + 2'd1;
              end
            end else begin
              jj <= jj + 2'd1;
            end
          end else begin
            jj <= jj + 2'd1;
          end
        end
        S_WAIT: begin
          // hold until the last product has reached the accumulator
          w <= 1'b1;
          if (w) begin
            part <= 1'b0;
            ii   <= '0;
            jj   <= '0;
            state <= S_MAC;
            unique case (phase)
              PH_A: begin
                a_reg <= acc[63:0];
                if (acc == '0) begin
                  i     <= i + CW'(1);
                  state <= S_LOOP;
                end else begin
                  phase <= PH_H;
                end
              end
              PH_H: begin
                h_reg <= acc_lo;
                phase <= PH_C;
              end
              PH_C: begin
                hm    <= 128'(h_reg < 0 ? -h_reg : h_reg);
                cm    <= 128'(acc_lo < 0 ? -acc_lo : acc_lo);
                am    <= 128'(a_reg);
                c_neg <= acc_lo < 0;
                phase <= PH_DISC;
              end
              PH_DISC: begin
                if (acc[ACC_W-1]) begin
                  i     <= i + CW'(1);
                  state <= S_LOOP;
                end else begin
                  ds_rad         <= acc[RAD_W-1:0];
                  ds_req.start   <= 1'b1;
                  ds_req.is_sqrt <= 1'b1;
                  root_run       <= 1'b1;
                  state          <= S_DS;
                end
              end
              PH_PDEN: begin
                if (acc == '0) begin
                  i     <= i + CW'(1);
                  state <= S_LOOP;
                end else begin
                  den_reg <= acc_lo;
                  phase   <= PH_PNUM;
                end
              end
              PH_PNUM: begin
                if (den_reg < 0) begin
                  ds_num <= NUM_W'(acc_lo);
                  ds_den <= NUM_W'(-den_reg);
                end else begin
                  ds_num <= -NUM_W'(acc_lo);
                  ds_den <= NUM_W'(den_reg);
                end
                ds_req.start <= 1'b1;
                root_run     <= 1'b0;
                state        <= S_DS;
              end
              default: state <= S_LOOP;
            endcase
          end
        end
        S_DS: begin
          if (ds_done) begin
            if (root_run) begin
              s_reg        <= ds_root;
              ds_num       <= -NUM_W'(h_reg) - $signed({4'b0000, ds_root});
              ds_den       <= NUM_W'(a_reg);
              ds_req.start <= 1'b1;
              root_run     <= 1'b0;
            end else if (is_sphere && !far && (ds_q == '0)) begin
              // near root not ahead of the origin: try the far one
              ds_num       <= -NUM_W'(h_reg) + $signed({4'b0000, s_reg});
              ds_req.start <= 1'b1;
              far          <= 1'b1;
            end else begin
              if ((ds_q != '0) && (!best_hit || (ds_q < best_t))) begin
                best_hit <= 1'b1;
                best_t   <= ds_q;
                best_i   <= i_ext[6:0];
              end
              i     <= i + CW'(1);
              state <= S_LOOP;
            end
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            out_hit   <= best_hit;
            out_dist  <= best_hit ? best_t : '0;
            out_entry <= best_hit ? best_i : '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/nhrc_mac.sv */
// Shared multiply-accumulate unit: registered 34x34 product, then a shifted
// add or subtract into a wide accumulator. Depends on nhrc_pkg.
module nhrc_mac (
  input  logic                      clk,
  input  logic                      rst,
  input  nhrc_pkg::mac_op_t         op,
  output logic signed [nhrc_pkg::ACC_W-1:0] acc
);
  import nhrc_pkg::*;

  logic                     v1;
  logic signed [PROD_W-1:0] prod1;
  logic [2:0]               sh1;
  logic                     neg1;
  logic                     clr1;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  base;

  always_comb begin
    term = ACC_W'(prod1) <<< {sh1, 5'b00000};
    if (neg1) term = -term;
    base = clr1 ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= op.valid;
    end
    prod1 <= op.a * op.b;
    sh1   <= op.sh;
    neg1  <= op.neg;
    clr1  <= op.clr;
    if (v1) acc <= base + term;
  end

endmodule

/* src/nhrc_divsqrt.sv */
// Iterative unit: digit-by-digit integer square root, or a restoring
// fixed-point quotient with saturation. Depends on nhrc_pkg.
module nhrc_divsqrt #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  nhrc_pkg::ds_req_t                   req,
  input  logic signed [nhrc_pkg::NUM_W-1:0]   num,
  input  logic [nhrc_pkg::NUM_W-1:0]          den,
  input  logic [nhrc_pkg::RAD_W-1:0]          rad,
  output logic                                done,
  output logic [nhrc_pkg::DIST_W-1:0]         q,
  output logic [nhrc_pkg::ROOT_W-1:0]         root
);
  import nhrc_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_SQRT, D_CHK, D_LOOP} ds_state_t;

  ds_state_t        state;
  logic [RAD_W-1:0] rem;
  logic [RAD_W-1:0] res;
  logic [RAD_W-1:0] one;
  logic [RAD_W-1:0] dsh;
  logic [6:0]       cnt;
  logic [RAD_W-1:0] trial;
  logic [RAD_W-1:0] res_next;
  logic             ge;

  always_comb begin
    trial = res + one;
    ge    = (state == D_SQRT) ? (rem >= trial) : (rem >= dsh);
    res_next = ge ? ((res >> 1) + one) : (res >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (req.start) begin
            if (req.is_sqrt) begin
              rem   <= rad;
              res   <= '0;
              one   <= RAD_W'(1) << (RAD_W - 2);
              cnt   <= 7'(RAD_W / 2 - 1);
              state <= D_SQRT;
            end else if (num <= 0) begin
              q    <= '0;
              done <= 1'b1;
            end else begin
              rem   <= RAD_W'(num) << FRAC_BITS;
              dsh   <= RAD_W'(den) << DIST_W;
              q     <= '0;
              state <= D_CHK;
            end
          end
        end
        D_SQRT: begin
          if (ge) rem <= rem - trial;
          res <= res_next;
          one <= one >> 2;
          cnt <= cnt - 7'd1;
          if (cnt == 7'd0) begin
            root  <= res_next[ROOT_W-1:0];
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        D_CHK: begin
          // saturate when the quotient would need 32 bits
          if (ge) begin
            q     <= DIST_MAX;
            done  <= 1'b1;
            state <= D_IDLE;
          end else begin
            dsh   <= dsh >> 1;
            cnt   <= 7'(DIST_W - 1);
            state <= D_LOOP;
          end
        end
        D_LOOP: begin
          if (ge) rem <= rem - dsh;
          q   <= {q[DIST_W-2:0], ge};
          dsh <= dsh >> 1;
          cnt <= cnt - 7'd1;
          if (cnt == 7'd0) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

/* tb/sv/nearest_hit_ray_caster_tb.sv */
// Self-checking testbench for nearest_hit_ray_caster: entry writes and ray casts
// with random handshake pressure, checked against a fixed-point nearest-hit predictor.
// Depends on nhrc_pkg and the nearest_hit_ray_caster RTL.
`timescale 1ns / 100ps

module nearest_hit_ray_caster_tb;
  import nhrc_pkg::*;

  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_THREE = 2'd3;
  localparam int TABLE_DEPTH = 128;
  localparam int SETTLE_CYCLES = 20;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic               op;
    logic [6:0]         idx;
    logic [1:0]         kind;
    logic signed [31:0] ax, ay, az, bx, by, bz;
    logic [30:0]        radius;
    logic               skip;
  } ray_word_t;

  typedef struct {
    logic        hit;
    logic [30:0] hit_dist;
    logic [6:0]  entry;
  } hit_word_t;

  class ray_hit_board;
    entry_t    table_q[TABLE_DEPTH];
    int        obj_count;
    hit_word_t pending_hits[$];
    int        mismatches;

    function new();
      obj_count = 0;
      mismatches = 0;
    endfunction

    function wide_t dot3(wide_t a0, wide_t a1, wide_t a2, wide_t b0, wide_t b1, wide_t b2);
      return a0 * b0 + a1 * b1 + a2 * b2;
    endfunction

    function wide_t root_floor(wide_t d);
      wide_t r;
      wide_t c;
      r = '0;
      for (int i = 66; i >= 0; i--) begin
        c = r + (wide_t'(1) <<< i);
        if (c * c <= d) r = c;
      end
      return r;
    endfunction

    // floor(num * 2^16 / den), saturated; den is positive
    function logic [30:0] dist_quot(wide_t num, wide_t den);
      wide_t q;
      if (num <= 0) return '0;
      q = (num <<< 16) / den;
      if (q >= (wide_t'(1) <<< 31)) return DIST_MAX;
      return q[30:0];
    endfunction

    function logic [30:0] sphere_t(ray_word_t w, entry_t e);
      wide_t lx, ly, lz, dx, dy, dz, a, h, c, rr, disc, s;
      logic [30:0] t;
      dx = wide_t'(w.bx); dy = wide_t'(w.by); dz = wide_t'(w.bz);
      lx = wide_t'(w.ax) - wide_t'(e.px);
      ly = wide_t'(w.ay) - wide_t'(e.py);
      lz = wide_t'(w.az) - wide_t'(e.pz);
      a = dot3(dx, dy, dz, dx, dy, dz);
      if (a == 0) return '0;
      h = dot3(dx, dy, dz, lx, ly, lz);
      rr = wide_t'({1'b0, e.radius});
      c = dot3(lx, ly, lz, lx, ly, lz) - rr * rr;
      disc = h * h - a * c;
      if (disc < 0) return '0;
      s = root_floor(disc);
      t = dist_quot(-h - s, a);
      if (t != 0) return t;
      return dist_quot(-h + s, a);
    endfunction

    function logic [30:0] plane_t(ray_word_t w, entry_t e);
      wide_t lx, ly, lz, num, den;
      wide_t nx, ny, nz;
      nx = wide_t'(e.nx); ny = wide_t'(e.ny); nz = wide_t'(e.nz);
      lx = wide_t'(w.ax) - wide_t'(e.px);
      ly = wide_t'(w.ay) - wide_t'(e.py);
      lz = wide_t'(w.az) - wide_t'(e.pz);
      den = dot3(nx, ny, nz, wide_t'(w.bx), wide_t'(w.by), wide_t'(w.bz));
      if (den == 0) return '0;
      num = -dot3(nx, ny, nz, lx, ly, lz);
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      return dist_quot(num, den);
    endfunction

    function void note_word(ray_word_t w);
      hit_word_t res;
      logic [30:0] t;
      int limit;
      if (w.op == OPC_WRITE) begin
        table_q[w.idx] = '{w.kind, w.ax, w.ay, w.az, w.bx, w.by, w.bz, w.radius};
        return;
      end
      res = '{1'b0, 31'd0, 7'd0};
      limit = obj_count < TABLE_DEPTH ? obj_count : TABLE_DEPTH;
      for (int i = 0; i < limit; i++) begin
        t = '0;
        if (w.skip && i == w.idx) continue;
        if (table_q[i].kind == KIND_SPHERE) t = sphere_t(w, table_q[i]);
        else if (table_q[i].kind == KIND_PLANE) t = plane_t(w, table_q[i]);
        if (t != 0 && (!res.hit || t < res.hit_dist)) res = '{1'b1, t, i[6:0]};
      end
      pending_hits.push_back(res);
    endfunction

    function void check_word(logic [39:0] data);
      hit_word_t want;
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", data);
        return;
      end
      want = pending_hits.pop_front();
      if (data[0] !== want.hit || data[31:1] !== want.hit_dist ||
          data[38:32] !== want.entry) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected hit %0d dist %h entry %0d,",
                    " got hit %0d dist %h entry %0d"},
                   want.hit, want.hit_dist, want.entry, data[0], data[31:1], data[38:32]);
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [239:0] s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [39:0]  m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_data = '0;

  ray_hit_board board = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  nearest_hit_ray_caster dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: stall at random, check each word taken
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_word(m_tdata);
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic signed [31:0] coord();
    if ($urandom_range(7) == 0) return $urandom;
    return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
  endfunction

  function automatic ray_word_t entry_word(logic [6:0] idx, logic [1:0] kind,
                                            logic signed [31:0] px, py, pz, nx, ny, nz,
                                            logic [30:0] radius);
    return '{OPC_WRITE, idx, kind, px, py, pz, nx, ny, nz, radius, 1'b0};
  endfunction

  function automatic ray_word_t ray_word(logic signed [31:0] ox, oy, oz, dx, dy, dz,
                                          logic skip, logic [6:0] idx);
    return '{OPC_CAST, idx, 2'($urandom_range(3)), ox, oy, oz, dx, dy, dz,
             31'($urandom), skip};
  endfunction

  task automatic send_word(ray_word_t w);
    s_tdata  <= {7'd0, w.skip, w.radius, w.bz, w.by, w.bx, w.az, w.ay, w.ax, w.kind, w.idx};
    s_tuser  <= w.op;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    board.note_word(w);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending_hits.size() != 0);
    // a trailing write gives no result; let it settle
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(logic [7:0] n);
    cfg_data  <= n;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.obj_count = int'(n);
    @(posedge clk);
  endtask

  task automatic random_phase(int n_words);
    ray_word_t w;
    int j;
    logic signed [31:0] ox, oy, oz;
    int sh;
    for (int k = 0; k < n_words; k++) begin
      if ($urandom_range(9) < 4) begin
        w = entry_word(7'($urandom_range(4) == 0 ? $urandom_range(127) : $urandom_range(7)),
                       2'($urandom_range(3)), coord(), coord(), coord(), coord(), coord(),
                       coord(),
                       31'($urandom_range(3) == 0 ? $urandom
                                                  : $urandom_range(0, 32'h0010_0000)));
      end else if ($urandom_range(9) < 8 && board.obj_count > 0) begin
        // aim at a live entry so that hits are common
        j = $urandom_range(board.obj_count - 1);
        ox = coord(); oy = coord(); oz = coord();
        sh = $urandom_range(4);
        w = ray_word(ox, oy, oz, (board.table_q[j].px - ox) >>> sh,
                     (board.table_q[j].py - oy) >>> sh, (board.table_q[j].pz - oz) >>> sh,
                     $urandom_range(3) == 0, 7'($urandom_range(127)));
      end else begin
        w = ray_word(coord(), coord(), coord(), coord(), coord(), coord(),
                     1'($urandom_range(1)), 7'($urandom_range(127)));
      end
      send_word(w);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_count(8'd0);

    // directed: shapes, ties, extremes
    send_word(entry_word(7'd0, KIND_SPHERE, 0, 0, 32'sh000A_0000, 0, 0, 0, 31'h0001_0000));
    send_word(entry_word(7'd1, KIND_PLANE, 0, 0, 32'sh0014_0000, 0, 0, 32'sh0001_0000,
                         31'd0));
    send_word(entry_word(7'd2, KIND_EMPTY, 0, 0, 0, 0, 0, 0, 31'd0));
    send_word(entry_word(7'd3, KIND_THREE, 0, 0, 32'sh0002_0000, 0, 0, 32'sh0001_0000,
                         31'h0001_0000));
    send_word(entry_word(7'd4, KIND_SPHERE, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                         0, 0, 0, 31'h7FFF_FFFF));
    send_word(entry_word(7'd5, KIND_PLANE, 32'shFFFB_0000, 0, 0, 32'sh0001_0000, 0, 0,
                         31'd0));
    send_word(entry_word(7'd6, KIND_SPHERE, 0, 0, 32'sh000A_0000, 0, 0, 0, 31'h0001_0000));
    send_word(entry_word(7'd7, KIND_PLANE, 32'sh7FFF_FFFF, 32'sh8000_0000, 0,
                         32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'd0));
    send_word(ray_word(0, 0, 0, 0, 0, 32'sh0001_0000, 1'b0, 7'd0));
    drain();
    set_count(8'd8);
    send_word(ray_word(0, 0, 0, 0, 0, 32'sh0001_0000, 1'b0, 7'd0));
    send_word(ray_word(0, 0, 0, 0, 0, 32'sh0001_0000, 1'b1, 7'd0));
    send_word(ray_word(0, 0, 0, 0, 0, 0, 1'b0, 7'd0));
    send_word(ray_word(0, 0, 0, 0, 32'sh0001_0000, 0, 1'b0, 7'd127));
    send_word(ray_word(0, 0, 32'sh000A_0000, 0, 0, 32'shFFFF_0000, 1'b0, 7'd0));
    send_word(ray_word(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                       32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 7'd127));
    send_word(ray_word(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                       32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 7'd5));
    drain();

    tx_idle_pct = 34; rx_idle_pct = 50;
    set_count(8'($urandom_range(1, 8)));
    random_phase(38);
    drain();
    tx_idle_pct = 50; rx_idle_pct = 34;
    set_count(8'($urandom_range(1, 8)));
    random_phase(38);
    drain();
    tx_idle_pct = 0; rx_idle_pct = 0;
    set_count(8'd8);
    random_phase(38);
    drain();

    if (board.mismatches == 0 && board.pending_hits.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
